// ----- rtl/eight_wheel_torsen_torque_split_assert.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef EIGHT_WHEEL_TORSEN_TORQUE_SPLIT_ASSERT_SVH
`define EIGHT_WHEEL_TORSEN_TORQUE_SPLIT_ASSERT_SVH
`ifndef SYNTHESIS
`define EWT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("assertion failed");
`define EWT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("assertion failed");
`else
`define EWT_ASSERT_SAME(label, ante, cons)
`define EWT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/ewt_pkg.sv -----
`timescale 1ns / 1ps
package ewt_pkg;

  localparam int NUM_AXLES = 4;
  localparam int NUM_SPEEDS = 8;
  localparam int B16_W = 24;
  localparam int NUM_W = 56;
  localparam int DEN_W = 27;
  localparam int Q_W = 30;
  localparam int LANE_LAT = 5 + Q_W;
  localparam int ITEM_LAT = LANE_LAT;
  localparam int CFG_AW = 4;
  localparam logic [15:0] BIAS_CAP_RST = 16'd512;
  localparam logic [24:0] BIAS_ONE = 25'h10000;

  typedef enum logic [1:0] {
    REG_AXLE1_BIAS,
    REG_AXLE2_BIAS,
    REG_AXLE3_BIAS,
    REG_AXLE4_BIAS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BIAS_FLAT,
    BIAS_RAMP,
    BIAS_MAX
  } bias_region_t;

  typedef struct packed {
    logic signed [31:0] drive_torque;
    logic signed [31:0] axle1_left_speed;
    logic signed [31:0] axle1_right_speed;
    logic signed [31:0] axle2_left_speed;
    logic signed [31:0] axle2_right_speed;
    logic signed [31:0] axle3_left_speed;
    logic signed [31:0] axle3_right_speed;
    logic signed [31:0] axle4_left_speed;
    logic signed [31:0] axle4_right_speed;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] axle1_left_torque;
    logic signed [31:0] axle1_right_torque;
    logic signed [31:0] axle2_left_torque;
    logic signed [31:0] axle2_right_torque;
    logic signed [31:0] axle3_left_torque;
    logic signed [31:0] axle3_right_torque;
    logic signed [31:0] axle4_left_torque;
    logic signed [31:0] axle4_right_torque;
    logic signed [31:0] shaft_speed;
  } out_res_t;

endpackage

// ----- rtl/ewt_div.sv -----
`timescale 1ns / 1ps
module ewt_div (
  input  logic                      clk,
  input  logic [ewt_pkg::NUM_W-1:0] num,
  input  logic [ewt_pkg::DEN_W-1:0] den,
  output logic [ewt_pkg::Q_W-1:0]   quo
);
  import ewt_pkg::*;

  localparam int W = DEN_W + Q_W;

  logic [NUM_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [W-1:0]     trial;
    logic [W:0]       dif;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign trial = W'(den_in) << (Q_W - 1 - i);
    assign dif   = {1'b0, W'(rem_in)} - {1'b0, trial};
    assign ge    = !dif[W];

    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? NUM_W'(dif[W-1:0]) : rem_in;
      den_r[i] <= den_in;
      q_r[i]   <= {q_in[Q_W-2:0], ge};
    end
  end

  assign quo = q_r[Q_W-1];
endmodule

// ----- rtl/ewt_lane.sv -----
`timescale 1ns / 1ps
module ewt_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic signed [31:0] torque,
  input  logic signed [31:0] sl,
  input  logic signed [31:0] sr,
  input  logic [15:0]        bias_cap,
  output logic signed [31:0] tl,
  output logic signed [31:0] tr
);
  import ewt_pkg::*;

  localparam int PW = FRAC_BITS + 21;
  localparam int SH = FRAC_BITS - 8;
  localparam int SIDE_D = 4 + Q_W;
  localparam logic [32:0] HALF = 33'(1) << (FRAC_BITS - 1);
  localparam logic [32:0] QTR = 33'(1) << (FRAC_BITS - 2);

  typedef struct packed {
    logic signed [31:0] quarter;
    logic               neg;
    logic               slow_left;
  } side_t;

  logic signed [32:0] dlt, mag_l, mag_r, tneg, tq;
  logic [32:0]        diff_nxt;
  side_t              side_nxt;

  logic [32:0]        diff_r;
  logic [31:0]        tmag1_r, tmag2_r, tmag3_r;
  logic [15:0]        m1_r, m2_r;
  side_t              side_r [SIDE_D];

  always_comb begin
    dlt      = $signed({sl[31], sl}) - $signed({sr[31], sr});
    diff_nxt = dlt[32] ? 33'(-dlt) : dlt;
    mag_l    = sl[31] ? -$signed({sl[31], sl}) : $signed({sl[31], sl});
    mag_r    = sr[31] ? -$signed({sr[31], sr}) : $signed({sr[31], sr});
    tneg     = -$signed({torque[31], torque});
    tq       = $signed({torque[31], torque}) + (torque[31] ? 33'sd3 : 33'sd0);
    side_nxt.quarter   = 32'(tq >>> 2);
    side_nxt.neg       = torque[31];
    side_nxt.slow_left = mag_l < mag_r;
  end

  always_ff @(posedge clk) begin
    diff_r    <= diff_nxt;
    tmag1_r   <= torque[31] ? tneg[31:0] : torque;
    m1_r      <= bias_cap;
    side_r[0] <= side_nxt;
    for (int k = 1; k < SIDE_D; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  logic signed [17:0]          msub;
  logic signed [FRAC_BITS:0]   dlow;
  logic signed [FRAC_BITS+18:0] prod;
  bias_region_t                region_nxt, region_r;
  logic signed [PW-1:0]        p_r;

  always_comb begin
    msub = $signed({2'b00, m1_r}) - 18'sd256;
    dlow = $signed({1'b0, diff_r[FRAC_BITS-1:0]});
    prod = msub * dlow;
    if (diff_r > HALF) begin
      region_nxt = BIAS_MAX;
    end else if (diff_r > QTR) begin
      region_nxt = BIAS_RAMP;
    end else begin
      region_nxt = BIAS_FLAT;
    end
  end

  always_ff @(posedge clk) begin
    p_r      <= $signed({prod, 2'b00});
    region_r <= region_nxt;
    m2_r     <= m1_r;
    tmag2_r  <= tmag1_r;
  end

  logic signed [PW-1:0] rnd, pdiv, ramp;
  logic signed [17:0]   bsub;
  logic signed [25:0]   base;
  logic [B16_W-1:0]     b16_nxt, b16_r;

  always_comb begin
    rnd  = p_r + (p_r[PW-1] ? PW'((1 << SH) - 1) : PW'(0));
    pdiv = rnd >>> SH;
    bsub = 18'sd512 - $signed({2'b00, m2_r});
    base = $signed({bsub, 8'b0});
    ramp = $signed({{(PW-26){base[25]}}, base}) + pdiv;
    case (region_r)
      BIAS_MAX:  b16_nxt = {m2_r, 8'b0};
      BIAS_RAMP: b16_nxt = ramp[PW-1] ? '0 : ramp[B16_W-1:0];
      default:   b16_nxt = B16_W'(BIAS_ONE);
    endcase
  end

  always_ff @(posedge clk) begin
    b16_r   <= b16_nxt;
    tmag3_r <= tmag2_r;
  end

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   quo;

  always_ff @(posedge clk) begin
    num_r <= tmag3_r * b16_r;
    den_r <= {(25'(b16_r) + BIAS_ONE), 2'b00};
  end

  ewt_div u_div (
    .clk (clk),
    .num (num_r),
    .den (den_r),
    .quo (quo)
  );

  side_t              sd;
  logic signed [31:0] slow, fast;

  always_comb begin
    sd   = side_r[SIDE_D-1];
    slow = sd.neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    fast = sd.quarter - slow;
  end

  always_ff @(posedge clk) begin
    tl <= sd.slow_left ? slow : fast;
    tr <= sd.slow_left ? fast : slow;
  end
endmodule

// ----- rtl/ewt_mean.sv -----
`timescale 1ns / 1ps
module ewt_mean (
  input  logic               clk,
  input  logic signed [31:0] spd [ewt_pkg::NUM_SPEEDS],
  output logic signed [31:0] mean
);
  import ewt_pkg::*;

  localparam int DLY = ITEM_LAT - 3;

  logic signed [32:0] s1_r [4];
  logic signed [33:0] s2_r [2];
  logic signed [34:0] s3_r, s3_adj;
  logic signed [31:0] dly_r [DLY];

  always_comb begin
    s3_adj = s3_r + (s3_r[34] ? 35'sd7 : 35'sd0);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      s1_r[k] <= 33'(spd[2*k]) + 33'(spd[2*k+1]);
    end
    for (int k = 0; k < 2; k++) begin
      s2_r[k] <= 34'(s1_r[2*k]) + 34'(s1_r[2*k+1]);
    end
    s3_r     <= 35'(s2_r[0]) + 35'(s2_r[1]);
    dly_r[0] <= 32'(s3_adj >>> 3);
    for (int k = 1; k < DLY; k++) begin
      dly_r[k] <= dly_r[k-1];
    end
  end

  assign mean = dly_r[DLY-1];
endmodule

// ----- rtl/eight_wheel_torsen_torque_split.sv -----
`timescale 1ns / 1ps
// Torque split for an eight-wheel driveline: one request carries the drive
// torque and eight wheel speeds, and the result carries eight wheel torques
// and the driveshaft speed. A request is taken on every cycle with start high
// (busy stays low), and its result appears with out_valid high for one
// cycle; the result's delay is set by the four axle lanes, each with a
// 30-stage pipelined divider. The receiver cannot stall the result, so it
// must take every result in the cycle it is shown. Bias registers may be
// written only while no request is in flight.
`include "eight_wheel_torsen_torque_split_assert.svh"
module eight_wheel_torsen_torque_split #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  ewt_pkg::in_req_t           in_req,
  output logic                       out_valid,
  output ewt_pkg::out_res_t          out_res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ewt_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ewt_pkg::*;

  logic [15:0]         mb_r [NUM_AXLES];
  logic [15:0]         mb_nxt [NUM_AXLES];
  logic [ITEM_LAT-1:0] vld_r, vld_nxt;
  logic                accept, wr_en;
  cfg_reg_t            idx;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = cfg_reg_t'(paddr[3:2]);

  always_comb begin
    mb_nxt = mb_r;
    if (wr_en) begin
      unique case (idx)
        REG_AXLE1_BIAS: mb_nxt[0] = pwdata[15:0];
        REG_AXLE2_BIAS: mb_nxt[1] = pwdata[15:0];
        REG_AXLE3_BIAS: mb_nxt[2] = pwdata[15:0];
        REG_AXLE4_BIAS: mb_nxt[3] = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AXLE1_BIAS: prdata = {16'b0, mb_r[0]};
      REG_AXLE2_BIAS: prdata = {16'b0, mb_r[1]};
      REG_AXLE3_BIAS: prdata = {16'b0, mb_r[2]};
      REG_AXLE4_BIAS: prdata = {16'b0, mb_r[3]};
      default:        prdata = '0;
    endcase
  end

  assign vld_nxt = {vld_r[ITEM_LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      for (int k = 0; k < NUM_AXLES; k++) begin
        mb_r[k] <= BIAS_CAP_RST;
      end
    end else begin
      vld_r <= vld_nxt;
      mb_r  <= mb_nxt;
    end
  end

  logic signed [31:0] spd [NUM_SPEEDS];
  logic signed [31:0] tl [NUM_AXLES];
  logic signed [31:0] tr [NUM_AXLES];
  logic signed [31:0] mean;

  assign spd[0] = in_req.axle1_left_speed;
  assign spd[1] = in_req.axle1_right_speed;
  assign spd[2] = in_req.axle2_left_speed;
  assign spd[3] = in_req.axle2_right_speed;
  assign spd[4] = in_req.axle3_left_speed;
  assign spd[5] = in_req.axle3_right_speed;
  assign spd[6] = in_req.axle4_left_speed;
  assign spd[7] = in_req.axle4_right_speed;

  for (genvar a = 0; a < NUM_AXLES; a++) begin : g_lane
    ewt_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .torque   (in_req.drive_torque),
      .sl       (spd[2*a]),
      .sr       (spd[2*a+1]),
      .bias_cap (mb_r[a]),
      .tl       (tl[a]),
      .tr       (tr[a])
    );
  end

  ewt_mean u_mean (
    .clk  (clk),
    .spd  (spd),
    .mean (mean)
  );

  assign out_valid = vld_r[ITEM_LAT-1];

  always_comb begin
    out_res.axle1_left_torque  = tl[0];
    out_res.axle1_right_torque = tr[0];
    out_res.axle2_left_torque  = tl[1];
    out_res.axle2_right_torque = tr[1];
    out_res.axle3_left_torque  = tl[2];
    out_res.axle3_right_torque = tr[2];
    out_res.axle4_left_torque  = tl[3];
    out_res.axle4_right_torque = tr[3];
    out_res.shaft_speed        = mean;
  end

  `EWT_ASSERT_SAME(a_lat_fwd, accept, ##ITEM_LAT out_valid)
  `EWT_ASSERT_SAME(a_lat_back, out_valid, $past(accept, ITEM_LAT))
  `EWT_ASSERT_NEXT(a_cfg_wr, wr_en && idx == REG_AXLE1_BIAS, mb_r[0] == $past(pwdata[15:0]))
endmodule
